// File: rtl/core/cfd_pkg.sv
// Shared types, constants and CRC update functions for the CRC-checked frame deframer.
// No dependencies; the interfaces, the CRC unit and the top level import it.
package cfd_pkg;

   localparam int BYTE_W       = 8;
   localparam int WORD_W       = 16;
   localparam int INDEX_W      = 7;
   localparam int STATUS_W     = 2;
   localparam int HEADER_BYTES = 4;

   localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'hA5;
   localparam logic [BYTE_W-1:0] CRC8_INIT        = 8'hFF;
   localparam logic [WORD_W-1:0] CRC16_INIT       = 16'hFFFF;
   localparam logic [BYTE_W-1:0] CRC8_POLY        = 8'h8C;
   localparam logic [WORD_W-1:0] CRC16_POLY       = 16'h8408;

   // Result kinds.
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // Frame verdict codes.
   localparam logic [STATUS_W-1:0] STATUS_GOOD     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BODY_CRC = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_HDR_CRC  = 2'd3;

   typedef struct packed {
      logic                  result_kind;
      logic [BYTE_W-1:0]     payload_byte;
      logic [INDEX_W-1:0]    payload_index;
      logic [WORD_W-1:0]     command_id;
      logic [BYTE_W-1:0]     frame_sequence;
      logic [WORD_W-1:0]     payload_length;
      logic [STATUS_W-1:0]   frame_status;
      logic                  frame_last;
   } rsp_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0] crc8;
      logic [WORD_W-1:0] crc16;
   } crc_pair_type;

   // Reflected CRC-8 (Maxim) over one byte, bit at a time.
   function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // Reflected CRC-16 (poly 0x8408) over one byte, bit at a time.
   function automatic logic [WORD_W-1:0] crc16_byte(input logic [WORD_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [WORD_W-1:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: rtl/core/cfd_req_if.sv
// Request channel of the frame deframer: one received byte per request.
// Depends on cfd_pkg for the byte width.
interface cfd_req_if;
   import cfd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/core/cfd_rsp_if.sv
// Response channel of the frame deframer: payload bytes and frame verdicts.
// Depends on cfd_pkg for field widths.
interface cfd_rsp_if;
   import cfd_pkg::*;

   logic                valid;
   logic                ready;
   logic                result_kind;
   logic [BYTE_W-1:0]   payload_byte;
   logic [INDEX_W-1:0]  payload_index;
   logic [WORD_W-1:0]   command_id;
   logic [BYTE_W-1:0]   frame_sequence;
   logic [WORD_W-1:0]   payload_length;
   logic [STATUS_W-1:0] frame_status;
   logic                frame_last;

   modport source (output valid, output result_kind, output payload_byte,
                   output payload_index, output command_id, output frame_sequence,
                   output payload_length, output frame_status, output frame_last,
                   input ready);
   modport sink   (input valid, input result_kind, input payload_byte,
                   input payload_index, input command_id, input frame_sequence,
                   input payload_length, input frame_status, input frame_last,
                   output ready);
endinterface

// File: rtl/core/cfd_crc_unit.sv
// Next-value logic for the header CRC-8 and the body CRC-16 over one byte.
// Depends on cfd_pkg for the CRC functions and the CRC pair struct.
module cfd_crc_unit (
   input  logic                        restart,
   input  cfd_pkg::crc_pair_type       crc_cur,
   input  logic [cfd_pkg::BYTE_W-1:0]  data,
   output cfd_pkg::crc_pair_type       crc_next
);
   import cfd_pkg::*;

   logic [BYTE_W-1:0] crc8_base;
   logic [WORD_W-1:0] crc16_base;

   // A start byte begins both checksums from their initial values.
   assign crc8_base     = restart ? CRC8_INIT  : crc_cur.crc8;
   assign crc16_base    = restart ? CRC16_INIT : crc_cur.crc16;
   assign crc_next.crc8  = crc8_byte(crc8_base, data);
   assign crc_next.crc16 = crc16_byte(crc16_base, data);

endmodule

// File: rtl/core/crc_checked_frame_deframer.sv
// Top level of the CRC-checked frame deframer: parser state and response register.
// Depends on cfd_pkg, cfd_req_if, cfd_rsp_if and cfd_crc_unit.
//
// Takes one received byte per request and accepts a new byte every clock cycle when the
// response register is free or draining; each byte is parsed in a single pass from the
// parser state into the response register, so a response appears in the cycle after its
// request is accepted. The response register is the only buffer: a request is taken
// whenever it is empty or being drained in the same cycle. A frame is the start byte, a
// little-endian length, a sequence byte, a header CRC-8, a little-endian command word,
// the payload and a little-endian CRC-16 over everything before it. Payload bytes are
// forwarded as they arrive; each frame attempt ends in one verdict response (good, body
// CRC mismatch, length too large, or header CRC mismatch). Lengths of MAX_FRAME_BYTES - 7
// or more are rejected. The user must set the start byte through the csr_ port only while
// the block is idle; the block itself does not enforce this.
module crc_checked_frame_deframer #(
   parameter int MAX_FRAME_BYTES = 128
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [cfd_pkg::BYTE_W-1:0] csr_wr_data,
   cfd_req_if.sink                    req_ch,
   cfd_rsp_if.source                  rsp_ch
);
   import cfd_pkg::*;

   localparam int LEN_LIMIT = MAX_FRAME_BYTES - HEADER_BYTES - 3;
   localparam int POS_W     = $clog2(MAX_FRAME_BYTES);

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_SEQ,
      PH_HCRC,
      PH_BODY
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [BYTE_W-1:0]  start_byte_ff, start_byte_in;
   logic [WORD_W-1:0]  length_ff, length_in;
   logic [BYTE_W-1:0]  seq_ff, seq_in;
   logic [WORD_W-1:0]  cmd_ff, cmd_in;
   logic [BYTE_W-1:0]  crc_low_ff, crc_low_in;
   crc_pair_type       crc_ff, crc_in, crc_next;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_ff, rsp_in;

   logic               req_accept;
   logic [BYTE_W-1:0]  rx;
   logic               emit;
   rsp_payload_type    result;
   logic [WORD_W-1:0]  length_full;
   logic [POS_W-1:0]   len_lo;
   logic [POS_W+6:0]   index_wide;

   assign rx         = req_ch.rx_byte;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_accept = req_ch.valid && req_ch.ready;

   cfd_crc_unit u_crc (
      .restart  (phase_ff == PH_HUNT),
      .crc_cur  (crc_ff),
      .data     (rx),
      .crc_next (crc_next)
   );

   assign length_full = {rx, length_ff[BYTE_W-1:0]};
   assign len_lo      = length_ff[POS_W-1:0];
   assign index_wide  = {7'b0, pos_ff - POS_W'(2)};

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      length_in  = length_ff;
      seq_in     = seq_ff;
      cmd_in     = cmd_ff;
      crc_low_in = crc_low_ff;
      crc_in     = crc_ff;
      emit       = 1'b0;
      result     = '0;

      unique case (phase_ff)
         PH_HUNT: begin
            if (rx == start_byte_ff) begin
               crc_in    = crc_next;
               length_in = '0;
               seq_in    = '0;
               cmd_in    = '0;
               pos_in    = '0;
               phase_in  = PH_LEN_LO;
            end
         end
         PH_LEN_LO: begin
            length_in = {8'h00, rx};
            crc_in    = crc_next;
            phase_in  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            length_in = length_full;
            crc_in    = crc_next;
            if (length_full >= WORD_W'(LEN_LIMIT)) begin
               emit                  = 1'b1;
               result.result_kind    = KIND_VERDICT;
               result.payload_length = length_full;
               result.frame_status   = STATUS_TOO_LONG;
               result.frame_last     = 1'b1;
               pos_in                = '0;
               phase_in              = PH_HUNT;
            end else begin
               phase_in = PH_SEQ;
            end
         end
         PH_SEQ: begin
            seq_in   = rx;
            crc_in   = crc_next;
            phase_in = PH_HCRC;
         end
         PH_HCRC: begin
            if (crc_ff.crc8 != rx) begin
               emit                  = 1'b1;
               result.result_kind    = KIND_VERDICT;
               result.frame_sequence = seq_ff;
               result.payload_length = length_ff;
               result.frame_status   = STATUS_HDR_CRC;
               result.frame_last     = 1'b1;
               pos_in                = '0;
               phase_in              = PH_HUNT;
            end else begin
               crc_in.crc16 = crc_next.crc16;
               pos_in       = '0;
               phase_in     = PH_BODY;
            end
         end
         PH_BODY: begin
            // Position counts command, payload and CRC bytes after the header.
            priority if (pos_ff == POS_W'(0)) begin
               cmd_in       = {8'h00, rx};
               crc_in.crc16 = crc_next.crc16;
               pos_in       = POS_W'(1);
            end else if (pos_ff == POS_W'(1)) begin
               cmd_in       = {rx, cmd_ff[BYTE_W-1:0]};
               crc_in.crc16 = crc_next.crc16;
               pos_in       = POS_W'(2);
            end else if (pos_ff < len_lo + POS_W'(2)) begin
               crc_in.crc16          = crc_next.crc16;
               pos_in                = pos_ff + POS_W'(1);
               emit                  = 1'b1;
               result.result_kind    = KIND_PAYLOAD;
               result.payload_byte   = rx;
               result.payload_index  = index_wide[INDEX_W-1:0];
               result.command_id     = cmd_ff;
               result.frame_sequence = seq_ff;
               result.payload_length = length_ff;
               result.frame_status   = STATUS_GOOD;
               result.frame_last     = 1'b0;
            end else if (pos_ff == len_lo + POS_W'(2)) begin
               crc_low_in = rx;
               pos_in     = pos_ff + POS_W'(1);
            end else begin
               emit                  = 1'b1;
               result.result_kind    = KIND_VERDICT;
               result.command_id     = cmd_ff;
               result.frame_sequence = seq_ff;
               result.payload_length = length_ff;
               result.frame_status   = ({rx, crc_low_ff} == crc_ff.crc16) ?
                                       STATUS_GOOD : STATUS_BODY_CRC;
               result.frame_last     = 1'b1;
               pos_in                = '0;
               phase_in              = PH_HUNT;
            end
         end
         default: begin
            pos_in   = '0;
            phase_in = PH_HUNT;
         end
      endcase
   end

   assign start_byte_in = csr_wr_en ? csr_wr_data : start_byte_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (req_accept) begin
         rsp_valid_in = emit;
         rsp_in       = result;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         pos_ff        <= '0;
         start_byte_ff <= START_BYTE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         start_byte_ff <= start_byte_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (req_accept) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (req_accept) begin
         length_ff  <= length_in;
         seq_ff     <= seq_in;
         cmd_ff     <= cmd_in;
         crc_low_ff <= crc_low_in;
         crc_ff     <= crc_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.result_kind    = rsp_ff.result_kind;
   assign rsp_ch.payload_byte   = rsp_ff.payload_byte;
   assign rsp_ch.payload_index  = rsp_ff.payload_index;
   assign rsp_ch.command_id     = rsp_ff.command_id;
   assign rsp_ch.frame_sequence = rsp_ff.frame_sequence;
   assign rsp_ch.payload_length = rsp_ff.payload_length;
   assign rsp_ch.frame_status   = rsp_ff.frame_status;
   assign rsp_ch.frame_last     = rsp_ff.frame_last;

   // A frame in its body always carries a length that passed the limit check.
   a_body_length_legal: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (length_ff < WORD_W'(LEN_LIMIT)))
      else $error("body phase with an oversized length");

   // The position counter is parked at zero while hunting.
   a_hunt_pos_zero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HUNT) |-> (pos_ff == '0))
      else $error("position not cleared while hunting");

   // Payload responses never close a frame and never carry an error status.
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.result_kind == KIND_PAYLOAD)) |->
      (!rsp_ff.frame_last && (rsp_ff.frame_status == STATUS_GOOD)))
      else $error("payload response with verdict fields set");

   // A stalled response register blocks new requests.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !req_accept)
      else $error("request accepted over a stalled response");

endmodule

// File: test/crc_checked_frame_deframer_test.sv
// Self-checking testbench for the CRC-checked frame deframer: a predictor class and the top bench.
// Depends on cfd_pkg, cfd_req_if, cfd_rsp_if and the crc_checked_frame_deframer RTL.
// Frames with random content and faults go in; every response is compared field by field.
package cfd_test_pkg;
   import cfd_pkg::*;

   typedef enum logic [2:0] {
      SEEK_START,
      TAKE_LEN_LO,
      TAKE_LEN_HI,
      TAKE_SEQUENCE,
      CHECK_HEADER,
      TAKE_BODY
   } parse_step_type;

   typedef enum int {
      FRAME_CLEAN,
      FRAME_BAD_BODY,
      FRAME_BAD_HEADER,
      FRAME_OVERSIZE
   } frame_flaw_type;

   // LSB-first CRC updates, one data bit at a time.
   function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      logic              fb;
      c = crc;
      for (int i = 0; i < BYTE_W; i++) begin
         fb = c[0] ^ data[i];
         c  = c >> 1;
         if (fb) c = c ^ CRC8_POLY;
      end
      return c;
   endfunction

   function automatic logic [WORD_W-1:0] crc16_update(input logic [WORD_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] data);
      logic [WORD_W-1:0] c;
      logic              fb;
      c = crc;
      for (int i = 0; i < BYTE_W; i++) begin
         fb = c[0] ^ data[i];
         c  = c >> 1;
         if (fb) c = c ^ CRC16_POLY;
      end
      return c;
   endfunction

   class deframe_scoreboard;
      parse_step_type    step;
      logic [BYTE_W-1:0] start_value;
      logic [WORD_W-1:0] body_pos;
      logic [WORD_W-1:0] frame_len;
      logic [BYTE_W-1:0] frame_seq;
      logic [WORD_W-1:0] frame_cmd;
      logic [BYTE_W-1:0] hdr_crc;
      logic [WORD_W-1:0] body_crc;
      logic [BYTE_W-1:0] crc_lo;
      int                len_limit;
      rsp_payload_type   awaited_responses[$];
      int                errors;
      int                requests;
      int                checked;

      function new(input int max_frame);
         len_limit   = max_frame - HEADER_BYTES - 3;
         start_value = START_BYTE_RESET;
         step        = SEEK_START;
         body_pos    = '0;
         frame_len   = '0;
         frame_seq   = '0;
         frame_cmd   = '0;
         hdr_crc     = CRC8_INIT;
         body_crc    = CRC16_INIT;
         crc_lo      = '0;
         errors      = 0;
         requests    = 0;
         checked     = 0;
      endfunction

      function void set_start(input logic [BYTE_W-1:0] value);
         start_value = value;
      endfunction

      function void restart();
         step     = SEEK_START;
         body_pos = '0;
      endfunction

      function rsp_payload_type verdict(input logic [STATUS_W-1:0] status,
                                        input logic [WORD_W-1:0] cmd,
                                        input logic [BYTE_W-1:0] seq);
         rsp_payload_type r;
         r                = '0;
         r.result_kind    = KIND_VERDICT;
         r.command_id     = cmd;
         r.frame_sequence = seq;
         r.payload_length = frame_len;
         r.frame_status   = status;
         r.frame_last     = 1'b1;
         return r;
      endfunction

      // Advances the parser by one accepted request and queues the response it causes.
      function void note_rx_byte(input logic [BYTE_W-1:0] b);
         rsp_payload_type r;
         requests++;
         r = '0;
         case (step)
            SEEK_START: begin
               if (b == start_value) begin
                  hdr_crc   = crc8_update(CRC8_INIT, b);
                  body_crc  = crc16_update(CRC16_INIT, b);
                  frame_len = '0;
                  frame_seq = '0;
                  frame_cmd = '0;
                  body_pos  = '0;
                  step      = TAKE_LEN_LO;
               end
            end
            TAKE_LEN_LO: begin
               frame_len = {8'h00, b};
               hdr_crc   = crc8_update(hdr_crc, b);
               body_crc  = crc16_update(body_crc, b);
               step      = TAKE_LEN_HI;
            end
            TAKE_LEN_HI: begin
               frame_len[15:8] = b;
               hdr_crc         = crc8_update(hdr_crc, b);
               body_crc        = crc16_update(body_crc, b);
               if (int'(frame_len) >= len_limit) begin
                  awaited_responses.push_back(verdict(STATUS_TOO_LONG, '0, '0));
                  restart();
               end else begin
                  step = TAKE_SEQUENCE;
               end
            end
            TAKE_SEQUENCE: begin
               frame_seq = b;
               hdr_crc   = crc8_update(hdr_crc, b);
               body_crc  = crc16_update(body_crc, b);
               step      = CHECK_HEADER;
            end
            CHECK_HEADER: begin
               if (b != hdr_crc) begin
                  awaited_responses.push_back(verdict(STATUS_HDR_CRC, '0, frame_seq));
                  restart();
               end else begin
                  body_crc = crc16_update(body_crc, b);
                  body_pos = '0;
                  step     = TAKE_BODY;
               end
            end
            TAKE_BODY: begin
               if (body_pos == 16'd0) begin
                  frame_cmd = {8'h00, b};
                  body_crc  = crc16_update(body_crc, b);
                  body_pos  = 16'd1;
               end else if (body_pos == 16'd1) begin
                  frame_cmd[15:8] = b;
                  body_crc        = crc16_update(body_crc, b);
                  body_pos        = 16'd2;
               end else if (int'(body_pos) < int'(frame_len) + 2) begin
                  r.result_kind    = KIND_PAYLOAD;
                  r.payload_byte   = b;
                  r.payload_index  = 7'(body_pos - 16'd2);
                  r.command_id     = frame_cmd;
                  r.frame_sequence = frame_seq;
                  r.payload_length = frame_len;
                  r.frame_status   = STATUS_GOOD;
                  r.frame_last     = 1'b0;
                  awaited_responses.push_back(r);
                  body_crc = crc16_update(body_crc, b);
                  body_pos = body_pos + 16'd1;
               end else if (int'(body_pos) == int'(frame_len) + 2) begin
                  crc_lo   = b;
                  body_pos = body_pos + 16'd1;
               end else begin
                  if ({b, crc_lo} == body_crc) begin
                     awaited_responses.push_back(verdict(STATUS_GOOD, frame_cmd, frame_seq));
                  end else begin
                     awaited_responses.push_back(verdict(STATUS_BODY_CRC, frame_cmd, frame_seq));
                  end
                  restart();
               end
            end
            default: restart();
         endcase
      endfunction

      task report(input string msg);
         errors++;
         if (errors <= 100) $display("MISMATCH: %s", msg);
      endtask

      task compare_field(input string name, input logic [WORD_W-1:0] got,
                         input logic [WORD_W-1:0] want);
         if (got !== want) begin
            report($sformatf("response %0d %s: got 0x%0h, expected 0x%0h",
                             checked, name, got, want));
         end
      endtask

      task check_response(input rsp_payload_type got);
         rsp_payload_type want;
         checked++;
         if (awaited_responses.size() == 0) begin
            report($sformatf("response %0d arrived with nothing expected", checked));
            return;
         end
         want = awaited_responses.pop_front();
         compare_field("result_kind", WORD_W'(got.result_kind), WORD_W'(want.result_kind));
         compare_field("payload_byte", WORD_W'(got.payload_byte), WORD_W'(want.payload_byte));
         compare_field("payload_index", WORD_W'(got.payload_index),
                       WORD_W'(want.payload_index));
         compare_field("command_id", got.command_id, want.command_id);
         compare_field("frame_sequence", WORD_W'(got.frame_sequence),
                       WORD_W'(want.frame_sequence));
         compare_field("payload_length", got.payload_length, want.payload_length);
         compare_field("frame_status", WORD_W'(got.frame_status), WORD_W'(want.frame_status));
         compare_field("frame_last", WORD_W'(got.frame_last), WORD_W'(want.frame_last));
      endtask
   endclass

endpackage

module crc_checked_frame_deframer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cfd_pkg::*;
   import cfd_test_pkg::*;

   localparam int HALF_PERIOD = 2;
   localparam int MAX_FRAME   = 128;
   localparam int LEN_LIMIT   = MAX_FRAME - HEADER_BYTES - 3;
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 64;
   localparam int PHASE_ITEMS = 250;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [BYTE_W-1:0] csr_wr_data;
   int                hold_asked = 0;
   int                hold_served = 0;
   int                hold_left = 0;
   int                req_idle_pct;
   int                rsp_idle_pct;
   int                sent_count;
   int                frame_tally[4];

   deframe_scoreboard board = new(MAX_FRAME);

   cfd_req_if req_ch();
   cfd_rsp_if rsp_ch();

   crc_checked_frame_deframer #(
      .MAX_FRAME_BYTES(MAX_FRAME)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch)
   );

   always #HALF_PERIOD clock = ~clock;

   // Both channels are sampled at the edge, before any of this edge's updates land.
   always @(posedge clock) begin
      rsp_payload_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) board.note_rx_byte(req_ch.rx_byte);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.result_kind    = rsp_ch.result_kind;
            got.payload_byte   = rsp_ch.payload_byte;
            got.payload_index  = rsp_ch.payload_index;
            got.command_id     = rsp_ch.command_id;
            got.frame_sequence = rsp_ch.frame_sequence;
            got.payload_length = rsp_ch.payload_length;
            got.frame_status   = rsp_ch.frame_status;
            got.frame_last     = rsp_ch.frame_last;
            board.check_response(got);
         end
      end
   end

   // Response sink: random stalls, plus a long hold-off on request from the driver.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= HOLD_CYCLES - 1;
         hold_served  <= hold_asked;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Timed out after %0d cycles without a handshake.", STALL_LIMIT);
      $display("crc_checked_frame_deframer_test: errors");
      $finish;
   end

   // Offers one request and returns at the edge where it is taken.
   task automatic send_byte(input logic [BYTE_W-1:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_frame(input logic [WORD_W-1:0] len, input logic [BYTE_W-1:0] seq,
                             input logic [WORD_W-1:0] cmd, input frame_flaw_type flaw);
      logic [BYTE_W-1:0] bytes[$];
      logic [BYTE_W-1:0] hcrc;
      logic [WORD_W-1:0] bcrc;
      bytes = {board.start_value, len[7:0], len[15:8]};
      if (flaw != FRAME_OVERSIZE) begin
         bytes.push_back(seq);
         hcrc = CRC8_INIT;
         foreach (bytes[i]) hcrc = crc8_update(hcrc, bytes[i]);
         if (flaw == FRAME_BAD_HEADER) hcrc = hcrc ^ 8'($urandom_range(1, 255));
         bytes.push_back(hcrc);
         // A header fault ends the frame here; the parser is back to hunting.
         if (flaw != FRAME_BAD_HEADER) begin
            bytes.push_back(cmd[7:0]);
            bytes.push_back(cmd[15:8]);
            for (int i = 0; i < int'(len); i++) bytes.push_back(8'($urandom));
            bcrc = CRC16_INIT;
            foreach (bytes[i]) bcrc = crc16_update(bcrc, bytes[i]);
            if (flaw == FRAME_BAD_BODY) bcrc = bcrc ^ 16'($urandom_range(1, 65535));
            bytes.push_back(bcrc[7:0]);
            bytes.push_back(bcrc[15:8]);
         end
      end
      frame_tally[int'(flaw)]++;
      foreach (bytes[i]) send_byte(bytes[i]);
   endtask

   task automatic send_random_frame();
      int                pick;
      logic [WORD_W-1:0] len;
      frame_flaw_type    flaw;
      pick = $urandom_range(99);
      if (pick < 5) begin
         // Line noise; it may well contain the start byte and derail the next frame.
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end else begin
         if (pick < 80) flaw = FRAME_CLEAN;
         else if (pick < 90) flaw = FRAME_BAD_BODY;
         else if (pick < 95) flaw = FRAME_BAD_HEADER;
         else flaw = FRAME_OVERSIZE;
         pick = $urandom_range(99);
         if (flaw == FRAME_OVERSIZE) begin
            if (pick < 40) len = 16'(LEN_LIMIT);
            else if (pick < 70) len = {board.start_value, 8'hFF};
            else len = 16'($urandom_range(LEN_LIMIT, 65535));
         end else if (pick < 80) begin
            len = 16'($urandom_range(0, 8));
         end else if (pick < 95) begin
            len = 16'($urandom_range(9, 40));
         end else begin
            len = 16'($urandom_range(LEN_LIMIT - 10, LEN_LIMIT - 1));
         end
         send_frame(len, 8'($urandom), 16'($urandom), flaw);
      end
   endtask

   task automatic random_traffic(input int items, input bit squeeze);
      int stop_at;
      bit held;
      stop_at = sent_count + items;
      held    = 1'b0;
      while (sent_count < stop_at) begin
         if (squeeze && !held && sent_count >= stop_at - items / 2) begin
            hold_asked <= hold_asked + 1;
            held = 1'b1;
         end
         send_random_frame();
      end
   endtask

   // Waits until the last request has been seen and no response is pending or queued.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.awaited_responses.size() != 0 || rsp_ch.valid) @(posedge clock);
   endtask

   // The start byte changes only once every expected response is in.
   task automatic set_start(input logic [BYTE_W-1:0] value);
      drain();
      repeat (3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_start(value);
   endtask

   initial begin
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      req_idle_pct   = 0;
      rsp_idle_pct   = 0;
      sent_count     = 0;
      foreach (frame_tally[i]) frame_tally[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct = 30;
      rsp_idle_pct <= 87;
      set_start(START_BYTE_RESET);
      send_byte(8'h00);
      send_frame(16'd0, 8'hFF, 16'hFFFF, FRAME_CLEAN);
      send_frame(16'(LEN_LIMIT), 8'h00, 16'h0000, FRAME_OVERSIZE);
      // Rejected high length byte equals the start byte and must not open a frame.
      send_frame({START_BYTE_RESET, 8'h00}, 8'h00, 16'h0000, FRAME_OVERSIZE);
      send_frame(16'd0, 8'h00, 16'h0000, FRAME_BAD_HEADER);
      send_frame(16'd1, 8'h5A, 16'h0000, FRAME_BAD_BODY);
      random_traffic(PHASE_ITEMS, 1'b0);

      set_start(8'h00);
      req_idle_pct = 87;
      rsp_idle_pct <= 30;
      random_traffic(PHASE_ITEMS, 1'b0);

      set_start(8'hFF);
      req_idle_pct = 0;
      rsp_idle_pct <= 0;
      random_traffic(PHASE_ITEMS, 1'b1);

      set_start(8'($urandom_range(1, 254)));
      random_traffic(PHASE_ITEMS / 3, 1'b0);

      drain();
      repeat (4) @(posedge clock);
      $display("Run covered %0d requests and %0d responses over four start-byte settings.",
               board.requests, board.checked);
      $display("Frames sent: %0d clean, %0d body CRC faults, %0d header CRC faults, %0d oversize.",
               frame_tally[0], frame_tally[1], frame_tally[2], frame_tally[3]);
      if (board.errors == 0) begin
         $display("crc_checked_frame_deframer_test: clean");
      end else begin
         $display("crc_checked_frame_deframer_test: errors");
      end
      $finish;
   end

endmodule
